FILE: rtl/fpvi_pkg.sv
package fpvi_pkg;

	localparam int MAX_SUBCELLS_DEF = 16;
	localparam int MAX_DEGREE_DEF   = 4;
	// quotient bits resolved in each divider stage
	localparam int DIV_STEPS_DEF    = 4;

	localparam int FACE_W     = 3;
	localparam int POINT_W    = 13;
	localparam int VOLUME_W   = 19;
	localparam int CELL_OUT_W = 4;
	localparam int NODE_OUT_W = 3;
	localparam int DEG_REG_W  = 3;
	localparam int SUB_REG_W  = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE_X   = 3'd0,
		REG_DEGREE_Y   = 3'd1,
		REG_DEGREE_Z   = 3'd2,
		REG_SUBCELLS_X = 3'd3,
		REG_SUBCELLS_Y = 3'd4,
		REG_SUBCELLS_Z = 3'd5
	} reg_idx_t;

	typedef enum logic {
		SIDE_LOW  = 1'b0,
		SIDE_HIGH = 1'b1
	} side_t;

	// first in-face axis, second in-face axis, normal axis, side
	typedef struct packed {
		axis_t a0;
		axis_t a1;
		axis_t a2;
		side_t side;
	} face_t;

	function automatic face_t face_lookup(input logic [FACE_W-1:0] f);
		face_t r;
		case (f)
			3'd0: r = '{AX_X, AX_Z, AX_Y, SIDE_LOW};
			3'd1: r = '{AX_Y, AX_Z, AX_X, SIDE_HIGH};
			3'd2: r = '{AX_Z, AX_X, AX_Y, SIDE_HIGH};
			3'd3: r = '{AX_Z, AX_Y, AX_X, SIDE_LOW};
			3'd4: r = '{AX_X, AX_Y, AX_Z, SIDE_HIGH};
			3'd5: r = '{AX_Y, AX_X, AX_Z, SIDE_LOW};
			default: r = '{AX_X, AX_Z, AX_Y, SIDE_LOW};
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/fpvi_div.sv
module fpvi_div #(
	parameter int DW    = 13,
	parameter int VW    = 3,
	parameter int STEPS = 4,
	parameter int PW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_dividend,
	input  logic [VW-1:0] in_divisor,
	input  logic [PW-1:0] in_payload,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_quotient,
	output logic [VW-1:0] out_remainder,
	output logic [PW-1:0] out_payload
);

	localparam int NS = (DW + STEPS - 1) / STEPS;

	// index 0 is the input side, 1..NS are registered stages
	logic          vld [NS+1];
	logic          rdy [NS+2];
	logic [DW-1:0] num [NS+1];
	logic [VW-1:0] rem [NS+1];
	logic [VW-1:0] dvs [NS+1];
	logic [PW-1:0] pay [NS+1];

	assign vld[0] = in_valid;
	assign num[0] = in_dividend;
	assign rem[0] = '0;
	assign dvs[0] = in_divisor;
	assign pay[0] = in_payload;

	assign rdy[NS+1] = out_ready;
	assign in_ready  = rdy[1];

	for (genvar k = 1; k <= NS; k++) begin : g_stage
		logic [DW-1:0] num_nx;
		logic [VW-1:0] rem_nx;

		assign rdy[k] = !vld[k] || rdy[k+1];

		// restoring division, quotient bits shift in at the bottom of num
		always_comb begin
			logic [VW:0] trial;
			num_nx = num[k-1];
			rem_nx = rem[k-1];
			for (int j = 0; j < STEPS; j++) begin
				if ((k - 1) * STEPS + j < DW) begin
					trial = {rem_nx, num_nx[DW-1]};
					if (trial >= {1'b0, dvs[k-1]}) begin
						trial  = trial - {1'b0, dvs[k-1]};
						num_nx = {num_nx[DW-2:0], 1'b1};
					end else begin
						num_nx = {num_nx[DW-2:0], 1'b0};
					end
					rem_nx = trial[VW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld[k] <= vld[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld[k-1]) begin
				num[k] <= num_nx;
				rem[k] <= rem_nx;
				dvs[k] <= dvs[k-1];
				pay[k] <= pay[k-1];
			end
		end
	end

	assign out_valid     = vld[NS];
	assign out_quotient  = num[NS];
	assign out_remainder = rem[NS];
	assign out_payload   = pay[NS];

endmodule

FILE: rtl/face_point_to_volume_index.sv
// Maps a point on one of the six faces of a hexahedral macrocell to the same point in
// the volume. Each input word carries the face number and the point's linear index on
// that face; each output word carries the volume index and the per-axis subcell and
// node indices, with out_of_range on tuser (face 6 or 7, or a point past the face, in
// which case all tdata fields are zero). One word is accepted per clock unless the output
// is held off, and every word yields exactly one result. Three chained 4-stage restoring
// dividers (13 quotient bits, 4 per stage) take the mixed-radix split; of six more stages,
// the first unpermutes the axes and each later one does one volume-index multiply-add.
// The config channel is always ready; registers are meant to change only while the block is empty.
module face_point_to_volume_index
	import fpvi_pkg::*;
#(
	parameter int MAX_SUBCELLS = MAX_SUBCELLS_DEF,
	parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // face, face_point
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [39:0]           m_axis_tdata,  // volume_index, cell_x, cell_y, cell_z,
	                                             // node_x, node_y, node_z
	output logic                  m_axis_tuser   // out_of_range
);

	localparam int DGW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
	localparam int DVW  = $clog2(MAX_DEGREE + 2);
	localparam int SW   = $clog2(MAX_SUBCELLS + 1);
	localparam int CW   = (MAX_SUBCELLS > 1) ? $clog2(MAX_SUBCELLS) : 1;
	localparam int VOLW = $clog2((MAX_DEGREE + 1) ** 3 * MAX_SUBCELLS ** 3 + 1);

	typedef struct packed {
		logic  bad;
		face_t f;
	} hdr_t;

	typedef struct packed {
		hdr_t           h;
		logic [DGW-1:0] pn0;
	} pay1_t;

	typedef struct packed {
		hdr_t           h;
		logic [DGW-1:0] pn0;
		logic [DGW-1:0] pn1;
	} pay2_t;

	typedef struct packed {
		logic                 oor;
		logic [2:0][DGW-1:0]  node;
		logic [2:0][CW-1:0]   subcell;
		logic [VOLW-1:0]      acc;
	} post_t;

	// configuration

	logic [DEG_REG_W-1:0] deg_q [3];
	logic [SUB_REG_W-1:0] sub_q [3];
	logic [DGW-1:0]       deg_e [3];
	logic [SW-1:0]        sub_e [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				deg_q[a] <= DEG_REG_W'(1);
				sub_q[a] <= SUB_REG_W'(1);
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEGREE_X:   deg_q[AX_X] <= cfg_data[DEG_REG_W-1:0];
				REG_DEGREE_Y:   deg_q[AX_Y] <= cfg_data[DEG_REG_W-1:0];
				REG_DEGREE_Z:   deg_q[AX_Z] <= cfg_data[DEG_REG_W-1:0];
				REG_SUBCELLS_X: sub_q[AX_X] <= cfg_data[SUB_REG_W-1:0];
				REG_SUBCELLS_Y: sub_q[AX_Y] <= cfg_data[SUB_REG_W-1:0];
				REG_SUBCELLS_Z: sub_q[AX_Z] <= cfg_data[SUB_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated degrees and subcell counts
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			deg_e[a] = (32'(deg_q[a]) > MAX_DEGREE) ? DGW'(MAX_DEGREE) : DGW'(deg_q[a]);
			if (sub_q[a] == '0)
				sub_e[a] = SW'(1);
			else if (32'(sub_q[a]) > MAX_SUBCELLS)
				sub_e[a] = SW'(MAX_SUBCELLS);
			else
				sub_e[a] = SW'(sub_q[a]);
		end
	end

	// divider chain

	hdr_t                in_hdr;
	logic [POINT_W-1:0]  in_point;

	always_comb begin
		in_hdr.bad = (s_axis_tdata[FACE_W-1:0] > FACE_W'(5));
		in_hdr.f   = face_lookup(s_axis_tdata[FACE_W-1:0]);
		in_point   = s_axis_tdata[FACE_W +: POINT_W];
	end

	logic               d0_valid, d0_ready;
	logic [POINT_W-1:0] d0_quo;
	logic [DVW-1:0]     d0_rem;
	hdr_t               d0_pay;

	fpvi_div #(
		.DW    (POINT_W),
		.VW    (DVW),
		.STEPS (DIV_STEPS_DEF),
		.PW    ($bits(hdr_t))
	) u_div0 (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_dividend   (in_point),
		.in_divisor    (DVW'(deg_e[in_hdr.f.a0]) + DVW'(1)),
		.in_payload    (in_hdr),
		.out_valid     (d0_valid),
		.out_ready     (d0_ready),
		.out_quotient  (d0_quo),
		.out_remainder (d0_rem),
		.out_payload   (d0_pay)
	);

	pay1_t              d1_in;
	logic               d1_valid, d1_ready;
	logic [POINT_W-1:0] d1_quo;
	logic [DVW-1:0]     d1_rem;
	pay1_t              d1_pay;

	assign d1_in = '{h: d0_pay, pn0: DGW'(d0_rem)};

	fpvi_div #(
		.DW    (POINT_W),
		.VW    (DVW),
		.STEPS (DIV_STEPS_DEF),
		.PW    ($bits(pay1_t))
	) u_div1 (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (d0_valid),
		.in_ready      (d0_ready),
		.in_dividend   (d0_quo),
		.in_divisor    (DVW'(deg_e[d0_pay.f.a1]) + DVW'(1)),
		.in_payload    (d1_in),
		.out_valid     (d1_valid),
		.out_ready     (d1_ready),
		.out_quotient  (d1_quo),
		.out_remainder (d1_rem),
		.out_payload   (d1_pay)
	);

	pay2_t              d2_in;
	logic               d2_valid;
	logic [POINT_W-1:0] d2_quo;
	logic [SW-1:0]      d2_rem;
	pay2_t              d2_pay;

	assign d2_in = '{h: d1_pay.h, pn0: d1_pay.pn0, pn1: DGW'(d1_rem)};

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	fpvi_div #(
		.DW    (POINT_W),
		.VW    (SW),
		.STEPS (DIV_STEPS_DEF),
		.PW    ($bits(pay2_t))
	) u_div2 (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (d1_valid),
		.in_ready      (d1_ready),
		.in_dividend   (d1_quo),
		.in_divisor    (sub_e[d1_pay.h.f.a0]),
		.in_payload    (d2_in),
		.out_valid     (d2_valid),
		.out_ready     (rdy_s1),
		.out_quotient  (d2_quo),
		.out_remainder (d2_rem),
		.out_payload   (d2_pay)
	);

	// unpermute and volume index

	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	post_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	post_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5, nx_s6;

	assign rdy_s6 = !vld_s6 || m_axis_tready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	always_comb begin
		face_t f;
		f = d2_pay.h.f;
		nx_s1     = '0;
		nx_s1.oor = d2_pay.h.bad || (32'(d2_quo) >= 32'(sub_e[f.a1]));
		if (!nx_s1.oor) begin
			for (int a = 0; a < 3; a++) begin
				if (2'(a) == f.a0) begin
					nx_s1.node[a]    = d2_pay.pn0;
					nx_s1.subcell[a] = CW'(d2_rem);
				end else if (2'(a) == f.a1) begin
					nx_s1.node[a]    = d2_pay.pn1;
					nx_s1.subcell[a] = CW'(d2_quo);
				end else if (f.side == SIDE_HIGH) begin
					nx_s1.node[a]    = deg_e[a];
					nx_s1.subcell[a] = CW'(sub_e[a] - SW'(1));
				end
			end
		end
	end

	// an out of range word has all indices zero, so its volume index comes out zero
	always_comb begin
		nx_s2     = st_s1;
		nx_s2.acc = VOLW'(st_s1.subcell[AX_Y]) +
			VOLW'(sub_e[AX_Y]) * VOLW'(st_s1.subcell[AX_Z]);
		nx_s3     = st_s2;
		nx_s3.acc = VOLW'(st_s2.subcell[AX_X]) + VOLW'(sub_e[AX_X]) * st_s2.acc;
		nx_s4     = st_s3;
		nx_s4.acc = VOLW'(st_s3.node[AX_Z]) + (VOLW'(deg_e[AX_Z]) + VOLW'(1)) * st_s3.acc;
		nx_s5     = st_s4;
		nx_s5.acc = VOLW'(st_s4.node[AX_Y]) + (VOLW'(deg_e[AX_Y]) + VOLW'(1)) * st_s4.acc;
		nx_s6     = st_s5;
		nx_s6.acc = VOLW'(st_s5.node[AX_X]) + (VOLW'(deg_e[AX_X]) + VOLW'(1)) * st_s5.acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= d2_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && d2_valid) st_s1 <= nx_s1;
		if (rdy_s2 && vld_s1)   st_s2 <= nx_s2;
		if (rdy_s3 && vld_s2)   st_s3 <= nx_s3;
		if (rdy_s4 && vld_s3)   st_s4 <= nx_s4;
		if (rdy_s5 && vld_s4)   st_s5 <= nx_s5;
		if (rdy_s6 && vld_s5)   st_s6 <= nx_s6;
	end

	assign m_axis_tvalid = vld_s6;
	assign m_axis_tuser  = st_s6.oor;
	assign m_axis_tdata  = {
		NODE_OUT_W'(st_s6.node[AX_Z]),
		NODE_OUT_W'(st_s6.node[AX_Y]),
		NODE_OUT_W'(st_s6.node[AX_X]),
		CELL_OUT_W'(st_s6.subcell[AX_Z]),
		CELL_OUT_W'(st_s6.subcell[AX_Y]),
		CELL_OUT_W'(st_s6.subcell[AX_X]),
		VOLUME_W'(st_s6.acc)
	};

`ifndef NO_ASSERTIONS
	// a flagged word carries nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("out of range word with nonzero data");

	// unpermuted subcells stay inside the configured grid
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !st_s1.oor |->
			32'(st_s1.subcell[AX_X]) < 32'(sub_e[AX_X]) &&
			32'(st_s1.subcell[AX_Y]) < 32'(sub_e[AX_Y]) &&
			32'(st_s1.subcell[AX_Z]) < 32'(sub_e[AX_Z]))
		else $error("subcell index past configured count");

	// node indices never exceed the saturated degree
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !st_s1.oor |->
			st_s1.node[AX_X] <= deg_e[AX_X] &&
			st_s1.node[AX_Y] <= deg_e[AX_Y] &&
			st_s1.node[AX_Z] <= deg_e[AX_Z])
		else $error("node index past degree");

	// input only backs up when the output is held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");
`endif

endmodule
